// ===== src/lph_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
package lph_pkg;

    // Fixed field widths
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 4;
    localparam int SLOT_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int NUM_BYTES   = WORD_W / BYTE_W;
    localparam int MAX_CHARS   = 8;
    // first + last character fits in nine bits
    localparam int SUM_W       = BYTE_W + 1;
    // Reciprocal scale for the home-slot reduction
    localparam int RECIP_SHIFT = 18;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // One request word
    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  word;
        logic [LEN_W-1:0]   word_len;
    } t_request;

    // One result word
    typedef struct packed {
        logic               found;
        logic               stored;
        logic               table_full;
        logic [SLOT_W-1:0]  slot;
    } t_result;

    // One table entry in slot memory
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [LEN_W-1:0]   len;
    } t_slot_entry;

endpackage

// ===== src/lph_home.sv =====
// Home-slot unit: (first + last) mod table size by reciprocal multiply and one correction.
module lph_home
    import lph_pkg::*;
#(
    parameter int TABLE_SIZE = 23
) (
    input  logic                           i_clk,
    input  logic [SUM_W-1:0]               i_sum,
    output logic [$clog2(TABLE_SIZE)-1:0]  o_home
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int RECIP  = (1 << RECIP_SHIFT) / TABLE_SIZE;
    localparam int PROD_W = SUM_W + RECIP_SHIFT;
    localparam int QC_W   = 2 * SUM_W;

    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  quot;
    logic [QC_W-1:0]   quot_mul;
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  rem_fix;

    // Quotient estimate, registered after the multiply
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
    end

    // Remainder; the estimate is at most one low, so one subtract corrects it
    always_comb begin
        quot     = r_prod[PROD_W-1 -: SUM_W];
        quot_mul = QC_W'(quot) * QC_W'(TABLE_SIZE);
        rem      = i_sum - quot_mul[SUM_W-1:0];
        if (rem >= SUM_W'(TABLE_SIZE)) begin
            rem_fix = rem - SUM_W'(TABLE_SIZE);
        end else begin
            rem_fix = rem;
        end
    end

    assign o_home = rem_fix[IDX_W-1:0];

endmodule

// ===== src/lph_slot_mem.sv =====
// Slot storage: one write port, one read port with registered read data.
module lph_slot_mem
    import lph_pkg::*;
#(
    parameter int TABLE_SIZE = 23
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0]  i_wr_addr,
    input  t_slot_entry                    i_wr_data,
    input  logic [$clog2(TABLE_SIZE)-1:0]  i_rd_addr,
    output t_slot_entry                    o_rd_data
);

    t_slot_entry r_mem [TABLE_SIZE];
    t_slot_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; read data is registered and appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/linear_probe_hash_table_unit.sv =====
// Top level: linear-probe hash table with probe sequencer and valid bits.
//
// Usage: a request word (insert or lookup of a 1..8 character word plus its
// length) is taken on a rising edge where start is high and busy is low.
// busy stays high while the request is worked on. The result word appears
// on o_result for exactly one cycle with o_done high; the receiver cannot
// hold it off, and a new request may be started in that same cycle.
// The request is worked on in order: the reciprocal multiply (S_MUL), the
// remainder to the home slot (S_HOME), then one slot a cycle from home on
// (S_PROBE, at most TABLE_SIZE slots) through the single read port of the
// slot memory and the shared word/length comparator. Requests do not
// overlap: the next start is taken at the edge that ends the o_done cycle.
// Insert takes the first empty slot from home on; lookup stops at a match
// or an empty slot; a probe over every slot without end raises table_full.
// Reset clears all valid bits at once, so the table starts empty; no
// clearing pass is needed.
module linear_probe_hash_table_unit
    import lph_pkg::*;
#(
    parameter int TABLE_SIZE = 23
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_request  i_req,
    output logic      o_done,
    output t_result   o_result
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_HOME,
        S_PROBE
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic                r_valid [TABLE_SIZE];
    logic                n_valid [TABLE_SIZE];
    logic                r_done, n_done;
    t_result             r_result, n_result;

    t_op                 r_op;
    logic [WORD_W-1:0]   r_word;
    logic [LEN_W-1:0]    r_len;
    logic [SUM_W-1:0]    r_sum;

    logic                accept;
    logic [LEN_W-1:0]    eff_len;
    logic [WORD_W-1:0]   masked_word;
    logic [BYTE_W-1:0]   last_char;
    logic [SUM_W-1:0]    hash_sum;

    logic [IDX_W-1:0]    home;
    logic [IDX_W-1:0]    nxt_pos;
    logic                cur_valid;
    logic                cur_match;
    logic                wr_en;
    t_slot_entry         rd_entry;
    t_slot_entry         wr_entry;
    logic [IDX_W+SLOT_W-1:0] cur_ext;

    assign accept = start && !busy;

    // Request prep: clamp length, mask unused bytes, pick last character, sum first and last
    always_comb begin
        if (i_req.word_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_req.word_len > LEN_W'(MAX_CHARS)) begin
            eff_len = LEN_W'(MAX_CHARS);
        end else begin
            eff_len = i_req.word_len;
        end
        masked_word = '0;
        last_char   = '0;
        for (int b = 0; b < NUM_BYTES; b++) begin
            if (LEN_W'(b) < eff_len) begin
                masked_word[b*BYTE_W +: BYTE_W] = i_req.word[b*BYTE_W +: BYTE_W];
            end
            if (LEN_W'(b + 1) == eff_len) begin
                last_char = i_req.word[b*BYTE_W +: BYTE_W];
            end
        end
        hash_sum = SUM_W'(masked_word[BYTE_W-1:0]) + SUM_W'(last_char);
    end

    // Request registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.op;
            r_word <= masked_word;
            r_len  <= eff_len;
            r_sum  <= hash_sum;
        end
    end

    lph_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .i_clk  (i_clk),
        .i_sum  (r_sum),
        .o_home (home)
    );

    assign wr_entry = '{word: r_word, len: r_len};

    lph_slot_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cur),
        .i_wr_data (wr_entry),
        .i_rd_addr (n_cur),
        .o_rd_data (rd_entry)
    );

    // Shared compare on the slot read this cycle
    assign cur_valid = r_valid[r_cur];
    assign cur_match = cur_valid && (rd_entry.len == r_len) && (rd_entry.word == r_word);
    assign nxt_pos   = (r_cur == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_cur + 1'b1;
    assign cur_ext   = {{SLOT_W{1'b0}}, r_cur};
    assign wr_en     = (r_state == S_PROBE) && (r_op == OP_INSERT) && !cur_valid;

    // Probe sequencer
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_valid  = r_valid;
        n_done   = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_HOME;
            end
            S_HOME: begin
                n_cur   = home;
                n_cnt   = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_op == OP_INSERT && !cur_valid) begin
                    n_valid[r_cur] = 1'b1;
                    n_result = '{found: 1'b0, stored: 1'b1, table_full: 1'b0,
                                 slot: cur_ext[SLOT_W-1:0]};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_op == OP_LOOKUP && !cur_valid) begin
                    n_result = '{found: 1'b0, stored: 1'b0, table_full: 1'b0,
                                 slot: '0};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_op == OP_LOOKUP && cur_match) begin
                    n_result = '{found: 1'b1, stored: 1'b0, table_full: 1'b0,
                                 slot: cur_ext[SLOT_W-1:0]};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_cnt == IDX_W'(TABLE_SIZE - 1)) begin
                    n_result = '{found: 1'b0, stored: 1'b0, table_full: 1'b1,
                                 slot: '0};
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cur = nxt_pos;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, valid bits and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_result <= '0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
            r_result <= n_result;
            r_valid  <= n_valid;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // A result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("o_done held longer than one cycle");

    // At most one outcome flag per result
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_result.found, o_result.stored, o_result.table_full}))
        else $error("more than one outcome flag set");

    // found only answers a lookup, stored only an insert
    a_op_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.found && r_op == OP_INSERT)
                && !(o_result.stored && r_op == OP_LOOKUP))
        else $error("outcome does not fit the operation");

    // A result only follows a probe cycle
    a_done_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_PROBE))
        else $error("result without a probe");

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted but block not busy");

endmodule
